// ===== rtl/core/fixed_point_binary_logarithm_unit_defines.svh =====
// Assertion macros shared by the logarithm unit RTL.
`ifndef FIXED_POINT_BINARY_LOGARITHM_UNIT_DEFINES_SVH
`define FIXED_POINT_BINARY_LOGARITHM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FLOG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FLOG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/flog_pkg.sv =====
// Package with the shared types and constants of the logarithm unit.
`timescale 1ns / 1ps

package flog_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [DATA_W-1:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [DATA_W-1:0] MIN_VAL = 32'h80000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SQR,
    S_SUM,
    S_MUL,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic sqr_step;
    logic sum;
    logic mul;
    logic shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic nonpos;
    logic nat;
  } status_t;

endpackage

// ===== rtl/core/fixed_point_binary_logarithm_unit.sv =====
// Top level of the fixed-point binary and natural logarithm unit.
// The unit takes a signed fixed-point operand with FRAC_BITS fraction bits and returns its
// base-2 logarithm, or with natural_i set the natural logarithm, in the same format. A zero
// or negative operand gives the most negative value (scaled by ln(2) in natural mode) and
// sets nonpositive_o. One transaction is in work at a time: the normalizer takes 0 to 7
// shift steps of up to four bits each, then the single squarer produces one fraction bit
// per cycle, and natural mode adds the ln(2) multiply and shift steps. The output
// register lets the next transaction be accepted while a result waits to be taken.
`timescale 1ns / 1ps

module fixed_point_binary_logarithm_unit import flog_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] operand_i,
  input  logic                     natural_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] logarithm_o,
  output logic                     nonpositive_o
);

  cmd_t    cmd;
  status_t status;

  flog_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  flog_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operand_i     (operand_i),
    .natural_i     (natural_i),
    .logarithm_o   (logarithm_o),
    .nonpositive_o (nonpositive_o)
  );

endmodule

// ===== rtl/core/flog_dpath.sv =====
// Datapath of the logarithm unit: normalizer, shared squarer, ln(2) multiplier, output register.
`timescale 1ns / 1ps

module flog_dpath import flog_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic signed [DATA_W-1:0] operand_i,
  input  logic                     natural_i,
  output logic signed [DATA_W-1:0] logarithm_o,
  output logic                     nonpositive_o
);

  localparam int unsigned EXP_W  = $clog2(DATA_W) + 2;
  localparam int unsigned MANT_W = FRAC_BITS + 1;
  localparam int unsigned SQ_W   = 2 * MANT_W;
  localparam int unsigned PROD_W = DATA_W + FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] LN2_K = LN2_Q32[DATA_W-1 -: FRAC_BITS];

  logic        [DATA_W-1:0]    m_q, m_d;
  logic signed [EXP_W-1:0]     expo_q, expo_d;
  logic        [FRAC_BITS-1:0] frac_q, frac_d;
  logic        [DATA_W-1:0]    lg_q, lg_d;
  logic signed [PROD_W-1:0]    prod_q, prod_d;
  logic                        nonpos_q, nonpos_d;
  logic                        nat_q, nat_d;
  logic        [DATA_W-1:0]    logarithm_q, logarithm_d;
  logic                        nonpositive_q, nonpositive_d;

  logic                        hi_any, hi_four, lo_four;
  logic        [MANT_W-1:0]    mant;
  logic        [SQ_W-1:0]      sq;
  logic        [MANT_W:0]      sq_sh;
  logic        [DATA_W-1:0]    expo_bits;

  assign hi_any  = |m_q[DATA_W-1:FRAC_BITS+1];
  assign hi_four = |m_q[DATA_W-1:FRAC_BITS+4];
  assign lo_four = ~|m_q[DATA_W-1:FRAC_BITS-4];

  assign mant  = m_q[MANT_W-1:0];
  assign sq    = mant * mant;
  assign sq_sh = sq[SQ_W-1:FRAC_BITS];

  assign expo_bits = DATA_W'(expo_q) << FRAC_BITS;
  assign prod_d    = PROD_W'(signed'(lg_q)) * PROD_W'(signed'({1'b0, LN2_K}));

  always_comb begin
    m_d           = m_q;
    expo_d        = expo_q;
    frac_d        = frac_q;
    lg_d          = lg_q;
    nonpos_d      = nonpos_q;
    nat_d         = nat_q;
    logarithm_d   = logarithm_q;
    nonpositive_d = nonpositive_q;
    if (cmd_i.load) begin
      m_d      = operand_i;
      expo_d   = '0;
      frac_d   = '0;
      nonpos_d = (operand_i == '0) || operand_i[DATA_W-1];
      nat_d    = natural_i;
      lg_d     = MIN_VAL;
    end
    if (cmd_i.norm_step) begin
      priority if (hi_four) begin
        m_d    = m_q >> 4;
        expo_d = expo_q + EXP_W'(4);
      end else if (hi_any) begin
        m_d    = m_q >> 1;
        expo_d = expo_q + EXP_W'(1);
      end else if (lo_four) begin
        m_d    = m_q << 4;
        expo_d = expo_q - EXP_W'(4);
      end else begin
        m_d    = m_q << 1;
        expo_d = expo_q - EXP_W'(1);
      end
    end
    if (cmd_i.sqr_step) begin
      if (sq_sh[MANT_W]) begin
        m_d    = DATA_W'(sq_sh[MANT_W:1]);
        frac_d = {frac_q[FRAC_BITS-2:0], 1'b1};
      end else begin
        m_d    = DATA_W'(sq_sh[MANT_W-1:0]);
        frac_d = {frac_q[FRAC_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.sum) begin
      lg_d = expo_bits + DATA_W'(frac_q);
    end
    if (cmd_i.shift) begin
      lg_d = prod_q[FRAC_BITS +: DATA_W];
    end
    if (cmd_i.out_load) begin
      logarithm_d   = lg_q;
      nonpositive_d = nonpos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonpos_q <= 1'b0;
      nat_q    <= 1'b0;
    end else begin
      nonpos_q <= nonpos_d;
      nat_q    <= nat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q           <= m_d;
    expo_q        <= expo_d;
    frac_q        <= frac_d;
    lg_q          <= lg_d;
    logarithm_q   <= logarithm_d;
    nonpositive_q <= nonpositive_d;
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign status_o.norm_done = !hi_any && m_q[FRAC_BITS];
  assign status_o.nonpos    = nonpos_q;
  assign status_o.nat       = nat_q;

  assign logarithm_o   = logarithm_q;
  assign nonpositive_o = nonpositive_q;

endmodule

// ===== rtl/core/flog_ctrl.sv =====
// Controller state machine of the logarithm unit, with the handshake flags.
`timescale 1ns / 1ps
`include "fixed_point_binary_logarithm_unit_defines.svh"

module flog_ctrl import flog_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.nonpos) begin
          state_d = status_i.nat ? S_MUL : S_DONE;
        end else if (status_i.norm_done) begin
          cnt_d   = '0;
          state_d = S_SQR;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      S_SQR: begin
        cmd_o.sqr_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = status_i.nat ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `FLOG_ASSERT_SAME(a_load_free_slot, cmd_o.out_load, slot_free, "Result loaded over an unread transaction")
  `FLOG_ASSERT_SAME(a_sqr_normalized, state_q == S_SQR, status_i.norm_done, "Squarer operand left the normalized range")
  `FLOG_ASSERT_SAME(a_sqr_count, state_q == S_SQR, cnt_q <= CNT_W'(FRAC_BITS - 1), "Fraction bit count overran")
  `FLOG_ASSERT_NEXT(a_accept_to_norm, in_valid_i && !in_stall_o, state_q == S_NORM, "Accepted transaction did not start normalization")

endmodule

// ===== sim/fixed_point_binary_logarithm_unit_test.sv =====
// Self-checking testbench for the fixed-point logarithm unit with random idling on both sides.
`timescale 1ns / 1ps

module fixed_point_binary_logarithm_unit_test;
  import flog_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC;
  localparam longint unsigned TWO_Q = 64'd2 << FRAC;
  localparam longint LN2_Q = longint'(LN2_Q32 >> (DATA_W - FRAC));
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [DATA_W-1:0] operand;
    logic              nat;
    int unsigned       gap;
  } operand_item_t;

  typedef struct {
    logic [DATA_W-1:0] logarithm;
    logic              nonpositive;
  } log_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] operand;
  logic                     natural_sel;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] logarithm;
  logic                     nonpositive;

  operand_item_t operands_to_send[$];
  log_result_t   expected_logs[$];
  int unsigned   wait_left;
  int unsigned   stall_left;
  int unsigned   stall_pick;
  int unsigned   cycles;
  int unsigned   errors;
  int unsigned   sent_count;
  int unsigned   sent_natural;
  int unsigned   checked_count;
  int unsigned   checked_nonpos;
  int unsigned   total_items;

  fixed_point_binary_logarithm_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .operand_i(operand),
    .natural_i(natural_sel),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .logarithm_o(logarithm),
    .nonpositive_o(nonpositive)
  );

  function automatic log_result_t predict_log(logic [DATA_W-1:0] raw, logic nat);
    log_result_t     r;
    longint unsigned m;
    int              expo;
    logic [DATA_W-1:0] frac;
    logic [DATA_W-1:0] lg;
    longint          prod;
    r.nonpositive = (raw == '0) || raw[DATA_W-1];
    if (r.nonpositive) begin
      lg = MIN_VAL;
    end else begin
      m = longint'(raw);
      expo = 0;
      frac = '0;
      while (m >= TWO_Q) begin
        expo++;
        m = m >> 1;
      end
      while (m < ONE_Q) begin
        expo--;
        m = m << 1;
      end
      for (int i = 0; i < FRAC; i++) begin
        frac = frac << 1;
        m = (m * m) >> FRAC;
        if (m >= TWO_Q) begin
          m = m >> 1;
          frac[0] = 1'b1;
        end
      end
      lg = (DATA_W'(expo) << FRAC) + frac;
    end
    if (nat) begin
      prod = longint'($signed(lg)) * LN2_Q;
      lg = DATA_W'(prod >>> FRAC);
    end
    r.logarithm = lg;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom();
      2, 3, 4, 5, 6: v = $urandom() >> $urandom_range(1, 31);
      7: v = 32'h0001_0000 + $urandom_range(0, 511) - 256;
      8: v = (32'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 1;
      default: v = -$urandom_range(0, 4);
    endcase
    return v;
  endfunction

  function automatic void add_operand(logic [DATA_W-1:0] v, logic nat, int unsigned gap);
    operand_item_t item;
    item.operand = v;
    item.nat = nat;
    item.gap = gap;
    operands_to_send.push_back(item);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles.", cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Driver: one transaction per handshake, with a gap taken before each queued operand.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      operand <= '0;
      natural_sel <= 1'b0;
      wait_left <= 0;
      sent_count <= 0;
      sent_natural <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_logs.push_back(predict_log(operand, natural_sel));
        sent_count <= sent_count + 1;
        sent_natural <= sent_natural + 32'(natural_sel);
      end
      if (wait_left > 0) begin
        in_valid <= 1'b0;
        wait_left <= wait_left - 1;
      end else if (operands_to_send.size() > 0) begin
        in_valid <= 1'b1;
        operand <= operands_to_send[0].operand;
        natural_sel <= operands_to_send[0].nat;
        void'(operands_to_send.pop_front());
        wait_left <= (operands_to_send.size() > 0) ? operands_to_send[0].gap : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      checked_count <= 0;
      checked_nonpos <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_logs.size() == 0) begin
          $display("%0t: unexpected result logarithm=%h nonpositive=%b",
                   $time, logarithm, nonpositive);
          errors++;
        end else begin
          if (logarithm !== expected_logs[0].logarithm) begin
            $display("%0t: logarithm mismatch, expected %h, actual %h",
                     $time, expected_logs[0].logarithm, logarithm);
            errors++;
          end
          if (nonpositive !== expected_logs[0].nonpositive) begin
            $display("%0t: nonpositive mismatch, expected %b, actual %b",
                     $time, expected_logs[0].nonpositive, nonpositive);
            errors++;
          end
          checked_nonpos <= checked_nonpos + 32'(expected_logs[0].nonpositive);
          void'(expected_logs.pop_front());
        end
        checked_count <= checked_count + 1;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (cycles[10] ^ cycles[12]) begin
        out_stall <= 1'b0;
      end else begin
        stall_pick = pick_gap();
        out_stall <= (stall_pick > 0);
        stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
      end
    end
  end

  initial begin
    errors = 0;
    rst_ni = 1'b0;
    for (int n = 0; n < 2; n++) begin
      add_operand(32'h0000_0000, n[0], 0);
      add_operand(32'h0000_0001, n[0], 0);
      add_operand(32'h0001_0000, n[0], 0);
      add_operand(32'h7FFF_FFFF, n[0], 0);
      add_operand(32'h8000_0000, n[0], 0);
      add_operand(32'hFFFF_FFFF, n[0], 0);
      add_operand(32'h0001_8000, n[0], 0);
      add_operand(32'h0000_FFFF, n[0], 0);
      add_operand(32'h4000_0000, n[0], 0);
      add_operand(32'h0002_0000, n[0], 0);
      add_operand(32'h5555_AAAA, n[0], 0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_operand(random_operand(), 1'($urandom_range(0, 1)),
                  ((i / 250) % 3 == 0) ? 0 : pick_gap());
    end
    total_items = operands_to_send.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (checked_count < total_items) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (expected_logs.size() != 0) begin
      $display("%0t: %0d results still outstanding", $time, expected_logs.size());
      errors++;
    end
    $display("Sent %0d operands (%0d in natural mode), checked %0d results.",
             sent_count, sent_natural, checked_count);
    $display("Nonpositive operands among them: %0d; mismatches: %0d.", checked_nonpos, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
